/* sv/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg: text console char writer shared definitions
// Field widths, control byte codes and the item structs used by the console
// writer, its channel interfaces and its sequencer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned ACTION_W = 1;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned CELL_W   = 16;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned ROW_O_W  = 5;
  localparam int unsigned COL_O_W  = 7;
  localparam int unsigned LOC_W    = 11;

  localparam logic [ACTION_W-1:0] ACT_PUT  = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_READ = 1'b1;

  localparam logic [CHAR_W-1:0] BYTE_BELL  = 8'h07;
  localparam logic [CHAR_W-1:0] BYTE_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] BYTE_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] BYTE_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] BYTE_SPACE = 8'h20;

  localparam logic [CELL_W-1:0]  BLANK_CELL  = 16'h0720;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   char_code;
    logic [INDEX_W-1:0]  cell_index;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]  cell_data;
    logic [ROW_O_W-1:0] cursor_row;
    logic [COL_O_W-1:0] cursor_col;
    logic [LOC_W-1:0]   cursor_location;
    logic               scrolled;
  } out_item_t;

endpackage

/* sv/tcw_if.sv */
// ----------------------------------------------------------------------------
// tcw_if: console writer channel interfaces
// Valid/ready channels for the request items and the result items.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::ACTION_W-1:0] action;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;
  logic [tcw_pkg::INDEX_W-1:0]  cell_index;

  modport source (output valid, action, char_code, cell_index, input ready);
  modport sink   (input valid, action, char_code, cell_index, output ready);
endinterface

interface tcw_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::CELL_W-1:0]  cell_data;
  logic [tcw_pkg::ROW_O_W-1:0] cursor_row;
  logic [tcw_pkg::COL_O_W-1:0] cursor_col;
  logic [tcw_pkg::LOC_W-1:0]   cursor_location;
  logic                        scrolled;

  modport source (output valid, cell_data, cursor_row, cursor_col, cursor_location,
                  scrolled, input ready);
  modport sink   (input valid, cell_data, cursor_row, cursor_col, cursor_location,
                  scrolled, output ready);
endinterface

/* sv/tcw_cell_ram.sv */
// ----------------------------------------------------------------------------
// tcw_cell_ram: screen cell store
// Simple dual port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
  parameter int unsigned DEPTH  = 2000,
  parameter int unsigned DATA_W = 16,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/tcw_ctrl.sv */
// ----------------------------------------------------------------------------
// tcw_ctrl: console writer sequencer
// Holds the cursor and colour, clears the store after reset, and walks each
// item through cell writes, tab fills, scroll copies and cell reads.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
  parameter int unsigned COLS  = 80,
  parameter int unsigned ROWS  = 25,
  localparam int unsigned CELLS = COLS * ROWS,
  localparam int unsigned AW    = $clog2(CELLS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          color_we_i,
  input  logic [tcw_pkg::COLOR_W-1:0]   color_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tcw_pkg::in_item_t             in_item_i,
  input  logic                          out_free_i,
  output logic                          res_valid_o,
  output tcw_pkg::out_item_t            res_o,
  output logic                          ram_we_o,
  output logic [AW-1:0]                 ram_waddr_o,
  output logic [tcw_pkg::CELL_W-1:0]    ram_wdata_o,
  output logic [AW-1:0]                 ram_raddr_o,
  input  logic [tcw_pkg::CELL_W-1:0]    ram_rdata_i
);

  localparam int unsigned RW = $clog2(ROWS + 1);
  localparam int unsigned CW = $clog2(COLS + 8);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_PUT    = 10'b00_0000_0100,
    S_TAB    = 10'b00_0000_1000,
    S_ADV    = 10'b00_0001_0000,
    S_SCROLL = 10'b00_0010_0000,
    S_DRAIN  = 10'b00_0100_0000,
    S_RD     = 10'b00_1000_0000,
    S_RDW    = 10'b01_0000_0000,
    S_FIN    = 10'b10_0000_0000
  } state_e;

  state_e                        state_q, state_d;
  logic [AW-1:0]                 cnt_q, cnt_d;
  logic [RW-1:0]                 row_q, row_d;
  logic [CW-1:0]                 col_q, col_d;
  logic [tcw_pkg::COLOR_W-1:0]   color_q, color_d;
  logic                          scrolled_q, scrolled_d;
  logic                          sw_v_q, sw_v_d;
  logic [AW-1:0]                 sw_addr_q, sw_addr_d;
  logic                          sw_copy_q, sw_copy_d;
  tcw_pkg::in_item_t             item_q, item_d;
  logic [tcw_pkg::CELL_W-1:0]    data_q, data_d;

  logic [AW-1:0]                 cell_addr;
  logic [AW:0]                   src_addr;
  logic [RW-1:0]                 row_n;
  logic [31:0]                   idx32;
  logic                          copy;

  assign in_ready_o = (state_q == S_IDLE);
  assign cell_addr  = AW'(int'(row_q) * COLS + int'(col_q));
  assign src_addr   = (AW + 1)'(cnt_q) + (AW + 1)'(COLS);
  assign idx32      = 32'(item_q.cell_index);
  assign copy       = (int'(cnt_q) < CELLS - COLS);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    row_d       = row_q;
    col_d       = col_q;
    color_d     = color_we_i ? color_i : color_q;
    scrolled_d  = scrolled_q;
    sw_v_d      = 1'b0;
    sw_addr_d   = sw_addr_q;
    sw_copy_d   = sw_copy_q;
    item_d      = item_q;
    data_d      = data_q;
    row_n       = row_q;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = cell_addr;
    ram_wdata_o = {color_q, item_q.char_code};
    ram_raddr_o = src_addr[AW-1:0];

    // delayed scroll write: copy the row below or fill with blanks
    if (sw_v_q) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = sw_addr_q;
      ram_wdata_o = sw_copy_q ? ram_rdata_i : {color_q, tcw_pkg::BYTE_SPACE};
    end

    case (state_q)
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cnt_q;
        ram_wdata_o = tcw_pkg::BLANK_CELL;
        cnt_d       = cnt_q + AW'(1);
        if (int'(cnt_q) == CELLS - 1) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          item_d     = in_item_i;
          data_d     = '0;
          scrolled_d = 1'b0;
          state_d    = (in_item_i.action == tcw_pkg::ACT_READ) ? S_RD : S_PUT;
        end
      end
      S_PUT: begin
        if (item_q.char_code == tcw_pkg::BYTE_BELL) begin
          state_d = S_FIN;
        end else if (item_q.char_code == tcw_pkg::BYTE_TAB) begin
          state_d = S_TAB;
        end else if (item_q.char_code == tcw_pkg::BYTE_CR ||
                     item_q.char_code == tcw_pkg::BYTE_LF) begin
          row_d   = row_q + RW'(1);
          col_d   = '0;
          state_d = S_ADV;
        end else begin
          if (item_q.char_code >= tcw_pkg::BYTE_SPACE) begin
            ram_we_o = 1'b1;
          end
          col_d   = col_q + CW'(1);
          state_d = S_ADV;
        end
      end
      S_TAB: begin
        // one blank per cycle up to the tab stop, nothing past the row end
        if (int'(col_q) < COLS) begin
          ram_we_o    = 1'b1;
          ram_wdata_o = {color_q, tcw_pkg::BYTE_SPACE};
        end
        col_d = col_q + CW'(1);
        if (col_q[2:0] == 3'b111) begin
          state_d = S_ADV;
        end
      end
      S_ADV: begin
        if (int'(col_q) >= COLS) begin
          col_d = CW'(int'(col_q) - COLS);
          row_n = row_q + RW'(1);
        end
        if (int'(row_n) >= ROWS) begin
          row_d      = RW'(ROWS - 1);
          scrolled_d = 1'b1;
          cnt_d      = '0;
          state_d    = S_SCROLL;
        end else begin
          row_d   = row_n;
          state_d = S_FIN;
        end
      end
      S_SCROLL: begin
        sw_v_d    = 1'b1;
        sw_addr_d = cnt_q;
        sw_copy_d = copy;
        cnt_d     = cnt_q + AW'(1);
        if (int'(cnt_q) == CELLS - 1) begin
          cnt_d   = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_RD: begin
        ram_raddr_o = idx32[AW-1:0];
        state_d     = S_RDW;
      end
      S_RDW: begin
        data_d  = (idx32 < CELLS) ? ram_rdata_i : '0;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.cell_data       = data_q;
    res_o.cursor_row      = tcw_pkg::ROW_O_W'(row_q);
    res_o.cursor_col      = tcw_pkg::COL_O_W'(col_q);
    res_o.cursor_location = tcw_pkg::LOC_W'(int'(row_q) * COLS + int'(col_q));
    res_o.scrolled        = scrolled_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      cnt_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
      color_q    <= tcw_pkg::COLOR_RESET;
      scrolled_q <= 1'b0;
      sw_v_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      row_q      <= row_d;
      col_q      <= col_d;
      color_q    <= color_d;
      scrolled_q <= scrolled_d;
      sw_v_q     <= sw_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sw_addr_q <= sw_addr_d;
    sw_copy_q <= sw_copy_d;
    item_q    <= item_d;
    data_q    <= data_d;
  end

endmodule

/* sv/text_console_char_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_console_char_writer_unit: text mode console character writer
// A COLS x ROWS store of attribute/glyph cells with a cursor, fed one put or
// read item at a time, returning the cursor and the read cell for each item.
// ----------------------------------------------------------------------------
// in_i carries action, char_code and cell_index; out_o returns one item per
// request with cell_data, the cursor after the request and a scroll flag.
// text_color_we_i/text_color_i load the attribute used for glyphs and blanks.
// An accepted plain byte, CR or LF passes through S_PUT and S_ADV to S_FIN,
// a bell goes from S_PUT straight to S_FIN, a read passes through S_RD and
// S_RDW, and a tab fills blanks in S_TAB up to its stop (at most 8). A put
// that passes the last row scrolls through the store one cell per cycle on
// the single read and write port, then passes S_DRAIN. From S_FIN the result
// moves into the output register. One item is in flight at a time; the next
// is accepted once the result has moved into the output register, even while
// that register still waits.
// After reset the store is filled with grey blanks, one cell per cycle,
// before the first item is accepted; the cursor starts at the top left and
// the color at 7. If the receiver stalls, the result holds in the output
// register and one more item may finish, then waits.
// ----------------------------------------------------------------------------
module text_console_char_writer_unit #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        text_color_we_i,
  input  logic [tcw_pkg::COLOR_W-1:0] text_color_i,
  tcw_in_if.sink                      in_i,
  tcw_out_if.source                   out_o
);

  localparam int unsigned CELLS = COLS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);

  tcw_pkg::in_item_t           in_item;
  tcw_pkg::out_item_t          res, out_q;
  logic                        res_valid;
  logic                        out_valid_q;
  logic                        out_free;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_wdata, ram_rdata;

  assign in_item.action     = in_i.action;
  assign in_item.char_code  = in_i.char_code;
  assign in_item.cell_index = in_i.cell_index;

  assign out_free = !out_valid_q || out_o.ready;

  tcw_ctrl #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .color_we_i  (text_color_we_i),
    .color_i     (text_color_i),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_item_i   (in_item),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  tcw_cell_ram #(
    .DEPTH  (CELLS),
    .DATA_W (tcw_pkg::CELL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.cell_data       = out_q.cell_data;
  assign out_o.cursor_row      = out_q.cursor_row;
  assign out_o.cursor_col      = out_q.cursor_col;
  assign out_o.cursor_location = out_q.cursor_location;
  assign out_o.scrolled        = out_q.scrolled;

  // a finished item never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_free)
    else $error("result loaded over a waiting result");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (int'(out_q.cursor_col) < COLS))
    else $error("cursor column out of range");

  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.scrolled) |->
      (out_q.cursor_row == tcw_pkg::ROW_O_W'(ROWS - 1)))
    else $error("scroll left cursor off the bottom row");

  a_scroll_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.scrolled) |-> (out_q.cell_data == '0))
    else $error("scrolling item carries cell data");

endmodule
